[hdl/fbpa_pkg.sv]
// Shared types and codes for the fixed block pool allocator.
// No dependencies; imported by fbpa_store and fixed_block_pool_allocator_unit.
`default_nettype none

package fbpa_pkg;

    typedef enum logic [1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_REINIT = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_BAD   = 2'd2;

    localparam logic [8:0] POOL_COUNT_RESET = 9'd256;

    typedef enum logic [1:0] {
        STATE_IDLE = 2'b01,
        STATE_BUSY = 2'b10
    } state_t;

    // Control group from the sequencer to the block store.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic wr_mark;
    } mem_ctl_t;

endpackage

`default_nettype wire

[hdl/fbpa_store.sv]
// Block store: one synchronous memory holding the allocated mark and free link per block.
// Entries at or above the watermark read as their rebuilt value. Depends on fbpa_pkg.
`default_nettype none

module fbpa_store
    import fbpa_pkg::*;
#(
    parameter int NUM_BLOCKS = 256
)
(
    input  wire logic                                  clk,
    input  wire mem_ctl_t                              ctl,
    input  wire logic [$clog2(NUM_BLOCKS)-1:0]         rd_addr,
    input  wire logic [$clog2(NUM_BLOCKS)-1:0]         wr_addr,
    input  wire logic [$clog2(NUM_BLOCKS+1)-1:0]       wr_link,
    input  wire logic [$clog2(NUM_BLOCKS+1)-1:0]       watermark,
    output logic      [$clog2(NUM_BLOCKS+1)-1:0]       rd_link,
    output logic                                       rd_mark,
    output logic                                       rd_fresh
);

    localparam int IW = $clog2(NUM_BLOCKS);
    localparam int LW = $clog2(NUM_BLOCKS + 1);

    // Word layout: mark in the top bit, link below it.
    logic [LW:0]   mem [NUM_BLOCKS];
    logic [LW:0]   rdata_reg;
    logic [IW-1:0] addr_reg;
    logic          fresh_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= {ctl.wr_mark, wr_link};
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
            addr_reg  <= rd_addr;
            fresh_reg <= (LW'(rd_addr) >= watermark);
        end
    end

    // An entry not touched since the last rebuild links to its successor and is free.
    always_comb
    begin
        if (fresh_reg)
        begin
            rd_link = LW'(addr_reg) + LW'(1);
            rd_mark = 1'b0;
        end
        else
        begin
            rd_link = rdata_reg[LW-1:0];
            rd_mark = rdata_reg[LW];
        end
    end

    assign rd_fresh = fresh_reg;

endmodule

`default_nettype wire

[hdl/fixed_block_pool_allocator_unit.sv]
// An accepted request starts the block store read and moves to the busy state; the result
// and any write-back are registered as the busy state ends, which waits while an earlier
// result is untaken. Every command, reinit too, is done before the next is accepted.
// Reset is asynchronous, active low, and needs no clearing pass: a watermark marks the
// store as freshly built, so the block accepts a request as soon as reset is released.
// Depends on fbpa_pkg and fbpa_store.
`default_nettype none

module fixed_block_pool_allocator_unit
    import fbpa_pkg::*;
#(
    parameter int NUM_BLOCKS = 256
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,    // [7:0] block_index
    input  wire logic [1:0] s_tuser,    // [1:0] cmd
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic      [7:0] m_tdata,    // [7:0] granted_index
    output logic      [1:0] m_tuser,    // [1:0] status
    input  wire logic       cfg_we,
    input  wire logic [8:0] cfg_wdata
);

    localparam int IW = $clog2(NUM_BLOCKS);
    localparam int LW = $clog2(NUM_BLOCKS + 1);

    state_t        state_reg,  state_next;
    logic [IW-1:0] head_reg,   head_next;
    logic [LW-1:0] count_reg,  count_next;
    logic [LW-1:0] wm_reg,     wm_next;
    logic [8:0]    pool_count_reg;
    cmd_t          cmd_reg;
    logic [IW-1:0] op_addr_reg;
    logic          idx_bad_reg;
    logic          m_tvalid_reg;
    logic [1:0]    status_reg, status_next;
    logic [7:0]    granted_reg, granted_next;

    logic          accept;
    logic          finish;
    logic [IW+7:0] idx_wide;
    logic [IW-1:0] idx_addr;
    logic [IW+7:0] head_wide;
    logic [LW-1:0] build_count;
    logic [LW-1:0] reset_count;
    logic [IW-1:0] rd_addr;
    mem_ctl_t      ctl;
    logic [LW-1:0] wr_link;
    logic [LW-1:0] rd_link;
    logic          rd_mark;
    logic          rd_fresh;

    assign s_tready = (state_reg == STATE_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign finish   = (state_reg == STATE_BUSY) && (!m_tvalid_reg || m_tready);

    assign idx_wide  = (IW + 8)'(s_tdata);
    assign idx_addr  = idx_wide[IW-1:0];
    assign head_wide = (IW + 8)'(head_reg);
    assign rd_addr   = (cmd_t'(s_tuser) == CMD_ALLOC) ? head_reg : idx_addr;

    assign build_count = (32'(pool_count_reg) > 32'(NUM_BLOCKS)) ? LW'(NUM_BLOCKS)
                                                                  : LW'(pool_count_reg);
    assign reset_count = (32'(POOL_COUNT_RESET) > 32'(NUM_BLOCKS)) ? LW'(NUM_BLOCKS)
                                                                    : LW'(POOL_COUNT_RESET);

    fbpa_store #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_store (
        .clk       (clk),
        .ctl       (ctl),
        .rd_addr   (rd_addr),
        .wr_addr   (op_addr_reg),
        .wr_link   (wr_link),
        .watermark (wm_reg),
        .rd_link   (rd_link),
        .rd_mark   (rd_mark),
        .rd_fresh  (rd_fresh)
    );

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        wm_next      = wm_reg;
        status_next  = status_reg;
        granted_next = granted_reg;
        ctl.rd_en    = accept;
        ctl.wr_en    = 1'b0;
        ctl.wr_mark  = 1'b0;
        wr_link      = rd_link;

        if (accept)
        begin
            state_next = STATE_BUSY;
        end

        if (finish)
        begin
            state_next   = STATE_IDLE;
            status_next  = STATUS_OK;
            granted_next = 8'd0;
            unique case (cmd_reg)
                CMD_ALLOC:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        ctl.wr_en    = 1'b1;
                        ctl.wr_mark  = 1'b1;
                        wr_link      = rd_link;
                        granted_next = head_wide[7:0];
                        count_next   = count_reg - LW'(1);
                        // A link past the last block is never followed; guard it to zero.
                        head_next    = (rd_link < LW'(NUM_BLOCKS)) ? rd_link[IW-1:0] : '0;
                        if (rd_fresh)
                        begin
                            wm_next = wm_reg + LW'(1);
                        end
                    end
                end
                CMD_FREE:
                begin
                    if (idx_bad_reg || !rd_mark)
                    begin
                        status_next = STATUS_BAD;
                    end
                    else
                    begin
                        ctl.wr_en   = 1'b1;
                        ctl.wr_mark = 1'b0;
                        wr_link     = LW'(head_reg);
                        head_next   = op_addr_reg;
                        count_next  = count_reg + LW'(1);
                    end
                end
                CMD_REINIT:
                begin
                    head_next  = '0;
                    wm_next    = '0;
                    count_next = build_count;
                end
                CMD_NOP:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= STATE_IDLE;
            head_reg       <= '0;
            count_reg      <= reset_count;
            wm_reg         <= '0;
            pool_count_reg <= POOL_COUNT_RESET;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            wm_reg    <= wm_next;
            if (cfg_we)
            begin
                pool_count_reg <= cfg_wdata;
            end
            if (finish)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg     <= cmd_t'(s_tuser);
            op_addr_reg <= rd_addr;
            idx_bad_reg <= (32'(s_tdata) >= 32'(NUM_BLOCKS));
        end
        status_reg  <= status_next;
        granted_reg <= granted_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = granted_reg;
    assign m_tuser  = status_reg;

endmodule

`default_nettype wire

[tb/sv/tb_fixed_block_pool_allocator_unit.sv]
// Testbench for fixed_block_pool_allocator_unit: directed and random allocate, free and
// reinit requests, checked against an in-bench model of the free list and allocated marks.
// Depends on fbpa_pkg and the allocator RTL.
module tb_fixed_block_pool_allocator_unit;
    import fbpa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_BLOCKS = 256;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] granted;
    } grant_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = '0;     // [7:0] block_index
    logic [1:0] s_tuser = '0;     // [1:0] cmd
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;          // [7:0] granted_index
    logic [1:0] m_tuser;          // [1:0] status
    logic       cfg_we = 1'b0;
    logic [8:0] cfg_wdata = '0;

    // Model of the pool.
    logic [8:0] pool_count_reg;
    logic [8:0] link_model [NUM_BLOCKS];
    logic [8:0] free_head;
    logic [8:0] free_total;
    logic       block_taken [NUM_BLOCKS];
    logic [7:0] held_blocks [$];
    logic [7:0] last_freed;

    grant_result_t expected_results [$];
    int fail_count = 0;
    int sink_hold_cycles = 0;
    bit no_idle = 1'b0;

    fixed_block_pool_allocator_unit #(.NUM_BLOCKS(NUM_BLOCKS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    function automatic int draw_gap();
        if (no_idle)
            return 0;
        return $urandom_range(0, 12);
    endfunction

    function automatic void rebuild_free_list();
        for (int i = 0; i < NUM_BLOCKS; i++)
        begin
            link_model[i] = 9'(i + 1);
            block_taken[i] = 1'b0;
        end
        free_head = '0;
        free_total = (pool_count_reg > NUM_BLOCKS) ? 9'(NUM_BLOCKS) : pool_count_reg;
        held_blocks.delete();
    endfunction

    function automatic grant_result_t predict_grant(cmd_t c, logic [7:0] idx);
        grant_result_t r;
        logic [8:0] blk;
        r.status = STATUS_OK;
        r.granted = '0;
        case (c)
            CMD_ALLOC:
            begin
                if (free_total == 0 || free_head >= NUM_BLOCKS)
                    r.status = STATUS_EMPTY;
                else
                begin
                    blk = free_head;
                    block_taken[blk[7:0]] = 1'b1;
                    // A link past the last block is read as block zero.
                    free_head = (link_model[blk[7:0]] < NUM_BLOCKS) ? link_model[blk[7:0]]
                                                                    : 9'd0;
                    free_total = free_total - 9'd1;
                    r.granted = blk[7:0];
                    held_blocks.push_back(blk[7:0]);
                end
            end
            CMD_FREE:
            begin
                if (!block_taken[idx])
                    r.status = STATUS_BAD;
                else
                begin
                    block_taken[idx] = 1'b0;
                    link_model[idx] = free_head;
                    free_head = {1'b0, idx};
                    free_total = free_total + 9'd1;
                    for (int k = 0; k < held_blocks.size(); k++)
                    begin
                        if (held_blocks[k] == idx)
                        begin
                            held_blocks.delete(k);
                            break;
                        end
                    end
                    last_freed = idx;
                end
            end
            CMD_REINIT:
                rebuild_free_list();
            default:
                ;
        endcase
        return r;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // Offers one request; valid stays high into the next request when there is no gap.
    task automatic send_request(input cmd_t c, input logic [7:0] idx);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= c;
        s_tdata <= idx;
        do
            @(posedge clk);
        while (!s_tready);
        expected_results.push_back(predict_grant(c, idx));
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_pool_count(input logic [8:0] value);
        wait_for_results();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        pool_count_reg = value;
    endtask

    task automatic send_alloc();
        send_request(CMD_ALLOC, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_held_free();
        if (held_blocks.size() == 0)
            send_request(CMD_FREE, 8'($urandom_range(0, 255)));
        else
            send_request(CMD_FREE, held_blocks[$urandom_range(0, held_blocks.size() - 1)]);
    endtask

    // Allocation order after reset, plain frees, a double free and the unused command code.
    task automatic test_reset_order();
        repeat (3) send_alloc();
        send_request(CMD_NOP, 8'hff);
        send_request(CMD_FREE, 8'd1);
        send_request(CMD_FREE, 8'd1);
        send_request(CMD_FREE, 8'd200);
        send_alloc();
        send_request(CMD_FREE, 8'd0);
        send_request(CMD_FREE, 8'd2);
        repeat (3) send_alloc();
        send_request(CMD_REINIT, 8'hff);
    endtask

    // Smallest, zero and stale counts.
    task automatic test_count_limits();
        write_pool_count(9'd1);
        send_request(CMD_REINIT, 8'd0);
        send_alloc();
        send_alloc();
        send_request(CMD_FREE, 8'd1);
        send_request(CMD_FREE, 8'd0);
        send_alloc();
        write_pool_count(9'd0);
        send_request(CMD_REINIT, 8'h55);
        send_alloc();
        send_request(CMD_FREE, 8'd0);
        // The pool keeps its built layout until the next reinit.
        write_pool_count(9'd2);
        send_alloc();
        send_request(CMD_FREE, 8'hff);
        send_request(CMD_REINIT, 8'haa);
        send_alloc();
    endtask

    // A count above the built size is clamped; draining the pool walks the last link.
    task automatic test_oversize_drain();
        write_pool_count(9'h1ff);
        send_request(CMD_REINIT, 8'd0);
        repeat (NUM_BLOCKS + 1) send_alloc();
        send_request(CMD_FREE, 8'd255);
        send_request(CMD_FREE, 8'd128);
        repeat (3) send_alloc();
    endtask

    // The receiver stalls long enough that the block backs up and holds off its input.
    task automatic test_backpressure();
        write_pool_count(9'd256);
        send_request(CMD_REINIT, 8'd0);
        no_idle = 1'b1;
        sink_hold_cycles = 150;
        for (int i = 0; i < 40; i++)
        begin
            if ($urandom_range(0, 2) == 0)
                send_held_free();
            else
                send_alloc();
        end
        no_idle = 1'b0;
        wait_for_results();
    endtask

    task automatic test_random_sessions();
        logic [8:0] counts [10];
        int r;
        counts = '{9'd1, 9'd2, 9'd3, 9'd5, 9'd16, 9'd100, 9'd256, 9'd0, 9'd511, 9'd255};
        for (int phase = 0; phase < 12; phase++)
        begin
            if (phase < 10)
                write_pool_count(counts[phase]);
            else
                write_pool_count(9'($urandom_range(0, 511)));
            no_idle = ($urandom_range(0, 3) == 0);
            send_request(CMD_REINIT, 8'($urandom_range(0, 255)));
            repeat (70)
            begin
                r = $urandom_range(0, 99);
                if (r < 52)
                    send_alloc();
                else if (r < 84)
                    send_held_free();
                else if (r < 89)
                    send_request(CMD_FREE, 8'($urandom_range(0, 255)));
                else if (r < 93)
                    send_request(CMD_FREE, last_freed);
                else if (r < 96)
                    send_request(CMD_REINIT, 8'($urandom_range(0, 255)));
                else
                    send_request(CMD_NOP, 8'($urandom_range(0, 255)));
            end
            no_idle = 1'b0;
        end
    endtask

    initial
    begin : result_sink
        int stall_left;
        grant_result_t want;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                    note_failure($sformatf("unexpected result status=%0d granted=%0d",
                                           m_tuser, m_tdata));
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tuser !== want.status)
                        note_failure($sformatf("status expected %0d actual %0d",
                                               want.status, m_tuser));
                    if (m_tdata !== want.granted)
                        note_failure($sformatf("granted_index expected %0d actual %0d",
                                               want.granted, m_tdata));
                end
                stall_left = draw_gap();
            end
            if (sink_hold_cycles > 0)
            begin
                stall_left = sink_hold_cycles;
                sink_hold_cycles = 0;
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin : run_limit
        #5_000_000;
        $display("fixed_block_pool_allocator_unit: mismatch");
        $finish;
    end

    initial
    begin : test_sequence
        last_freed = '0;
        pool_count_reg = POOL_COUNT_RESET;
        rebuild_free_list();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_order();
        test_count_limits();
        test_oversize_drain();
        test_backpressure();
        test_random_sessions();
        wait_for_results();
        if (fail_count == 0 && expected_results.size() == 0)
            $display("fixed_block_pool_allocator_unit: match");
        else
            $display("fixed_block_pool_allocator_unit: mismatch");
        $finish;
    end

endmodule
